// ===== sv/qsu_pkg.sv =====
// Shared types, constants and helper functions for the quoted string unescape core.
// No dependencies; every other file refers to this package by scoped names.

package qsu_pkg;

   localparam int MAX_CHARS = 65535;
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int NBYTES    = 5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_A  = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_X     = 8'h78;

   localparam logic [31:0] UTF8_LIM1 = 32'h80;
   localparam logic [31:0] UTF8_LIM2 = 32'h800;
   localparam logic [31:0] UTF8_LIM3 = 32'h10000;
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;
   localparam logic [31:0] UTF8_MASK  = 32'h3F;

   localparam logic [3:0] LIMIT_OCT = 4'd3;
   localparam logic [3:0] LIMIT_U   = 4'd4;
   localparam logic [3:0] LIMIT_X   = 4'd8;

   localparam logic [1:0] ST_PARSING = 2'd0;
   localparam logic [1:0] ST_CLOSED  = 2'd1;
   localparam logic [1:0] ST_ERROR   = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_XU,
      PH_DIGITS,
      PH_DONE,
      PH_ERR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OCT,
      KIND_U,
      KIND_X
   } kind_type;

   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_BYTE,
      PRE_BSPAIR,
      PRE_UTF8
   } pre_type;

   typedef struct packed {
      pre_type     pre;
      logic [7:0]  pre_byte;
      logic [31:0] code;
      logic        tail;
   } plan_type;

   typedef struct packed {
      logic [NBYTES-1:0][7:0] bytes;
      logic [2:0]             nbytes;
      logic [1:0]             status;
      logic [15:0]            chars;
   } pkt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      n;
   } utf8_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_val(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.val   = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         h.val = c[3:0];
      end else if ((c >= CH_LA && c <= CH_LF_A) || (c >= CH_UA && c <= CH_UF)) begin
         h.val = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic utf8_type utf8_enc(input logic [31:0] cp);
      utf8_type u;
      u.b = '0;
      if (cp < UTF8_LIM1) begin
         u.n    = 3'd1;
         u.b[0] = cp[7:0];
      end else if (cp < UTF8_LIM2) begin
         u.n    = 3'd2;
         u.b[0] = UTF8_LEAD2 | cp[13:6];
         u.b[1] = UTF8_CONT | (cp[7:0] & UTF8_MASK[7:0]);
      end else if (cp < UTF8_LIM3) begin
         u.n    = 3'd3;
         u.b[0] = UTF8_LEAD3 | cp[19:12];
         u.b[1] = UTF8_CONT | (cp[13:6] & UTF8_MASK[7:0]);
         u.b[2] = UTF8_CONT | (cp[7:0] & UTF8_MASK[7:0]);
      end else begin
         u.n    = 3'd4;
         u.b[0] = UTF8_LEAD4 | cp[25:18];
         u.b[1] = UTF8_CONT | (cp[19:12] & UTF8_MASK[7:0]);
         u.b[2] = UTF8_CONT | (cp[13:6] & UTF8_MASK[7:0]);
         u.b[3] = UTF8_CONT | (cp[7:0] & UTF8_MASK[7:0]);
      end
      return u;
   endfunction

endpackage

// ===== sv/qsu_front.sv =====
// Front end: parse state machine; classifies each accepted character into one packet of 0 to 5 bytes.
// Depends on qsu_pkg.

module qsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [7:0]       req_ch,
   input  logic             req_start_req,
   output qsu_pkg::pkt_type pkt
);

   qsu_pkg::phase_type       phase_ff, phase_in;
   logic [31:0]              acc_ff, acc_in;
   logic [3:0]               dcnt_ff, dcnt_in;
   qsu_pkg::kind_type        kind_ff, kind_in;
   logic [qsu_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   qsu_pkg::plan_type        plan;

   always_comb begin
      logic               run_body;
      qsu_pkg::hex_type   h;
      logic               dvalid;
      logic [3:0]         dval;
      logic [31:0]        acc_new;
      logic [3:0]         dcnt_new;
      logic [3:0]         limit;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      dcnt_in       = dcnt_ff;
      kind_in       = kind_ff;
      cnt_in        = cnt_ff;
      plan.pre      = qsu_pkg::PRE_NONE;
      plan.pre_byte = req_ch;
      plan.code     = acc_ff;
      plan.tail     = 1'b0;
      run_body      = 1'b0;
      h             = qsu_pkg::hex_val(req_ch);
      dvalid        = 1'b0;
      dval          = 4'd0;
      acc_new       = acc_ff;
      dcnt_new      = dcnt_ff + 4'd1;
      limit         = qsu_pkg::LIMIT_X;
      if (req_start_req) begin
         acc_in   = '0;
         dcnt_in  = '0;
         kind_in  = qsu_pkg::KIND_OCT;
         cnt_in   = qsu_pkg::CNT_W'(1);
         phase_in = (req_ch == qsu_pkg::CH_QUOTE) ? qsu_pkg::PH_BODY : qsu_pkg::PH_ERR;
      end else if (phase_ff == qsu_pkg::PH_BODY || phase_ff == qsu_pkg::PH_ESC ||
                   phase_ff == qsu_pkg::PH_XU || phase_ff == qsu_pkg::PH_DIGITS) begin
         if (cnt_ff < qsu_pkg::CNT_W'(qsu_pkg::MAX_CHARS)) begin
            cnt_in = cnt_ff + qsu_pkg::CNT_W'(1);
         end
         case (phase_ff)
            qsu_pkg::PH_BODY: begin
               run_body = 1'b1;
            end
            qsu_pkg::PH_ESC: begin
               phase_in = qsu_pkg::PH_BODY;
               if (req_ch == qsu_pkg::CH_NUL) begin
                  phase_in = qsu_pkg::PH_ERR;
               end else if (req_ch == qsu_pkg::CH_BSL || req_ch == qsu_pkg::CH_QUOTE ||
                            req_ch == qsu_pkg::CH_APOS) begin
                  plan.pre = qsu_pkg::PRE_BYTE;
               end else if (req_ch == qsu_pkg::CH_N) begin
                  plan.pre      = qsu_pkg::PRE_BYTE;
                  plan.pre_byte = qsu_pkg::CH_LF;
               end else if (req_ch == qsu_pkg::CH_R) begin
                  plan.pre      = qsu_pkg::PRE_BYTE;
                  plan.pre_byte = qsu_pkg::CH_CR;
               end else if (req_ch == qsu_pkg::CH_T) begin
                  plan.pre      = qsu_pkg::PRE_BYTE;
                  plan.pre_byte = qsu_pkg::CH_TAB;
               end else if (req_ch >= qsu_pkg::CH_ZERO && req_ch <= qsu_pkg::CH_SEVEN) begin
                  acc_in   = 32'(req_ch[2:0]);
                  dcnt_in  = 4'd1;
                  kind_in  = qsu_pkg::KIND_OCT;
                  phase_in = qsu_pkg::PH_DIGITS;
               end else if (req_ch == qsu_pkg::CH_X || req_ch == qsu_pkg::CH_U) begin
                  kind_in  = (req_ch == qsu_pkg::CH_U) ? qsu_pkg::KIND_U : qsu_pkg::KIND_X;
                  phase_in = qsu_pkg::PH_XU;
               end else begin
                  plan.pre = qsu_pkg::PRE_BSPAIR;
               end
            end
            qsu_pkg::PH_XU: begin
               if (h.valid) begin
                  acc_in   = 32'(h.val);
                  dcnt_in  = 4'd1;
                  phase_in = qsu_pkg::PH_DIGITS;
               end else begin
                  plan.pre      = qsu_pkg::PRE_BSPAIR;
                  plan.pre_byte = (kind_ff == qsu_pkg::KIND_U) ? qsu_pkg::CH_U : qsu_pkg::CH_X;
                  run_body      = 1'b1;
               end
            end
            qsu_pkg::PH_DIGITS: begin
               if (kind_ff == qsu_pkg::KIND_OCT) begin
                  limit   = qsu_pkg::LIMIT_OCT;
                  dvalid  = (req_ch >= qsu_pkg::CH_ZERO && req_ch <= qsu_pkg::CH_SEVEN);
                  dval    = {1'b0, req_ch[2:0]};
                  acc_new = {acc_ff[28:0], 3'b000} | 32'(dval);
               end else begin
                  limit   = (kind_ff == qsu_pkg::KIND_U) ? qsu_pkg::LIMIT_U : qsu_pkg::LIMIT_X;
                  dvalid  = h.valid;
                  dval    = h.val;
                  acc_new = {acc_ff[27:0], 4'b0000} | 32'(dval);
               end
               if (dvalid) begin
                  acc_in  = acc_new;
                  dcnt_in = dcnt_new;
                  if (dcnt_new >= limit) begin
                     plan.pre  = qsu_pkg::PRE_UTF8;
                     plan.code = acc_new;
                     phase_in  = qsu_pkg::PH_BODY;
                  end
               end else begin
                  plan.pre = qsu_pkg::PRE_UTF8;
                  run_body = 1'b1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (run_body) begin
            if (req_ch == qsu_pkg::CH_NUL || req_ch == qsu_pkg::CH_LF ||
                req_ch == qsu_pkg::CH_CR) begin
               phase_in = qsu_pkg::PH_ERR;
            end else if (req_ch == qsu_pkg::CH_QUOTE) begin
               phase_in = qsu_pkg::PH_DONE;
            end else if (req_ch == qsu_pkg::CH_BSL) begin
               phase_in = qsu_pkg::PH_ESC;
            end else begin
               plan.tail = 1'b1;
               phase_in  = qsu_pkg::PH_BODY;
            end
         end
      end
   end

   always_comb begin
      logic [qsu_pkg::NBYTES-1:0][7:0] bytes;
      logic [2:0]                      nb;
      qsu_pkg::utf8_type               u;
      bytes = '0;
      nb    = 3'd0;
      u     = qsu_pkg::utf8_enc(plan.code);
      case (plan.pre)
         qsu_pkg::PRE_BYTE: begin
            bytes[nb] = plan.pre_byte;
            nb        = nb + 3'd1;
         end
         qsu_pkg::PRE_BSPAIR: begin
            bytes[nb] = qsu_pkg::CH_BSL;
            nb        = nb + 3'd1;
            bytes[nb] = plan.pre_byte;
            nb        = nb + 3'd1;
         end
         qsu_pkg::PRE_UTF8: begin
            for (int i = 0; i < 4; i++) begin
               if (3'(i) < u.n) begin
                  bytes[nb] = u.b[i];
                  nb        = nb + 3'd1;
               end
            end
         end
         default: begin
            nb = 3'd0;
         end
      endcase
      if (plan.tail) begin
         bytes[nb] = req_ch;
         nb        = nb + 3'd1;
      end
      pkt.bytes  = bytes;
      pkt.nbytes = nb;
      case (phase_in)
         qsu_pkg::PH_DONE: pkt.status = qsu_pkg::ST_CLOSED;
         qsu_pkg::PH_ERR:  pkt.status = qsu_pkg::ST_ERROR;
         default:          pkt.status = qsu_pkg::ST_PARSING;
      endcase
      pkt.chars = (phase_in == qsu_pkg::PH_DONE) ? 16'(cnt_in) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qsu_pkg::PH_IDLE;
         acc_ff   <= '0;
         dcnt_ff  <= '0;
         kind_ff  <= qsu_pkg::KIND_OCT;
         cnt_ff   <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         dcnt_ff  <= dcnt_in;
         kind_ff  <= kind_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== sv/qsu_queue.sv =====
// Packet queue between front and back end; register storage, one push and one pop per cycle.
// Depends on qsu_pkg.

module qsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qsu_pkg::pkt_type   push_pkt,
   input  logic               pop,
   output qsu_pkg::pkt_type   head,
   output qsu_pkg::qstat_type qstat
);

   qsu_pkg::pkt_type          mem_ff [qsu_pkg::QDEPTH];
   logic [qsu_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [qsu_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [qsu_pkg::QPTR_W:0]   cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == (qsu_pkg::QPTR_W + 1)'(qsu_pkg::QDEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign head        = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + qsu_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + qsu_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (qsu_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (qsu_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/qsu_back.sv =====
// Back end: splits head packet into beats of one byte, or one empty beat.
// Depends on qsu_pkg.

module qsu_back (
   input  logic               clock,
   input  logic               reset,
   input  qsu_pkg::pkt_type   head,
   input  qsu_pkg::qstat_type qstat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_chars_read,
   output logic               rsp_last
);

   logic [2:0] idx_ff, idx_in;
   logic [2:0] nbeats;
   logic       fire;

   assign rsp_valid      = !qstat.empty;
   assign nbeats         = (head.nbytes == 3'd0) ? 3'd1 : head.nbytes;
   assign rsp_last       = (idx_ff == nbeats - 3'd1);
   assign rsp_byte_valid = (head.nbytes != 3'd0);
   assign rsp_out_byte   = rsp_byte_valid ? head.bytes[idx_ff] : 8'd0;
   assign rsp_status     = head.status;
   assign rsp_chars_read = head.chars;
   assign fire           = rsp_valid && rsp_ready;
   assign pop            = fire && rsp_last;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = 3'd0;
      end else if (fire) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== sv/quoted_string_unescape_utf8_core.sv =====
// Top level of the quoted string unescape core: front parser, packet queue, beat serializer.
// Depends on qsu_pkg, qsu_front, qsu_queue, qsu_back.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_ch[7:0], req_start_req
//   rsp      out  rsp_valid/rsp_ready  rsp_out_byte[7:0], rsp_byte_valid, rsp_status[1:0],
//                                      rsp_chars_read[15:0], rsp_last
//
// One character accepted per cycle while the 4-entry packet queue has room.
// Each character yields max(1, decoded bytes) response beats, 1 to 5.
// Each accepted character's packet is registered in the queue; its first beat appears once it reaches the head.
// Synchronous reset returns the parser to idle and empties the queue.
// req_ready depends only on queue occupancy, not on rsp_ready.

module quoted_string_unescape_utf8_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_chars_read,
   output logic        rsp_last
);

   qsu_pkg::pkt_type   push_pkt;
   qsu_pkg::pkt_type   head;
   qsu_pkg::qstat_type qstat;
   logic               push;
   logic               pop;

   assign req_ready = !qstat.full;
   assign push      = req_valid && req_ready;

   qsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .req_ch        (req_ch),
      .req_start_req (req_start_req),
      .pkt           (push_pkt)
   );

   qsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   qsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_chars_read (rsp_chars_read),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sv/qsu_checker.sv =====
// Port-level checker for the quoted string unescape core, attached by bind.
// Depends on qsu_pkg and quoted_string_unescape_utf8_core.

module qsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_chars_read,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_out_byte == 8'd0)
      else $error("beat without byte is not a lone last beat");

   a_count_only_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != qsu_pkg::ST_CLOSED |-> rsp_chars_read == 16'd0)
      else $error("chars_read nonzero while not closed");

   a_status_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && $stable(rsp_status))
      else $error("status changed within one character's beats");

endmodule

bind quoted_string_unescape_utf8_core qsu_checker u_qsu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_status     (rsp_status),
   .rsp_chars_read (rsp_chars_read),
   .rsp_last       (rsp_last)
);

// ===== sim/tb_quoted_string_unescape_utf8_core.sv =====
// Testbench for quoted_string_unescape_utf8_core: directed table, then random quoted strings.
// Predicts every response beat in-line and compares in order; depends on qsu_pkg and the core.
`timescale 1ns / 100ps

module tb_quoted_string_unescape_utf8_core;

   localparam int WATCHDOG_CYCLES = 4000;
   localparam int PHASE_ITEMS     = 70;
   localparam int NROWS           = 26;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [1:0]  status;
      logic [15:0] chars_read;
      logic        last;
   } rsp_beat_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        start;
      logic        known;
      logic [1:0]  status;
      logic [15:0] chars_read;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        req_start_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_chars_read;
   logic        rsp_last;

   int src_idle = 35;
   int rsp_idle = 52;
   int sent_items;
   int mismatches;
   int stall_cycles;

   rsp_beat_type expected_beats[$];
   logic [7:0]   dec_bytes[$];
   dir_row_type  dir_tab [NROWS];

   qsu_pkg::phase_type dec_phase = qsu_pkg::PH_IDLE;
   qsu_pkg::kind_type  dec_kind = qsu_pkg::KIND_OCT;
   logic [31:0]        dec_code = '0;
   logic [3:0]         dec_ndig = '0;
   int                 dec_count = 0;

   quoted_string_unescape_utf8_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_chars_read (rsp_chars_read),
      .rsp_last       (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle);
   end

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= qsu_pkg::CH_ZERO && c <= qsu_pkg::CH_NINE) return c - qsu_pkg::CH_ZERO;
      if (c >= qsu_pkg::CH_LA && c <= qsu_pkg::CH_LF_A) return c - qsu_pkg::CH_LA + 10;
      if (c >= qsu_pkg::CH_UA && c <= qsu_pkg::CH_UF) return c - qsu_pkg::CH_UA + 10;
      return -1;
   endfunction

   task automatic emit_byte(input logic [7:0] b);
      dec_bytes.push_back(b);
   endtask

   task automatic emit_code_point(input logic [31:0] cp);
      if (cp < 32'h80) begin
         emit_byte(cp[7:0]);
      end else if (cp < 32'h800) begin
         emit_byte(8'hC0 | cp[13:6]);
         emit_byte({2'b10, cp[5:0]});
      end else if (cp < 32'h10000) begin
         emit_byte(8'hE0 | cp[19:12]);
         emit_byte({2'b10, cp[11:6]});
         emit_byte({2'b10, cp[5:0]});
      end else begin
         emit_byte(8'hF0 | cp[25:18]);
         emit_byte({2'b10, cp[17:12]});
         emit_byte({2'b10, cp[11:6]});
         emit_byte({2'b10, cp[5:0]});
      end
   endtask

   task automatic body_char(input logic [7:0] c);
      if (c == qsu_pkg::CH_NUL || c == qsu_pkg::CH_LF || c == qsu_pkg::CH_CR) begin
         dec_phase = qsu_pkg::PH_ERR;
      end else if (c == qsu_pkg::CH_QUOTE) begin
         dec_phase = qsu_pkg::PH_DONE;
      end else if (c == qsu_pkg::CH_BSL) begin
         dec_phase = qsu_pkg::PH_ESC;
      end else begin
         emit_byte(c);
         dec_phase = qsu_pkg::PH_BODY;
      end
   endtask

   task automatic decode_char(input logic [7:0] c, input logic s,
                              output logic [1:0] st, output logic [15:0] cnt);
      int         hv;
      logic [3:0] lim;
      dec_bytes.delete();
      if (s) begin
         dec_code  = '0;
         dec_ndig  = '0;
         dec_kind  = qsu_pkg::KIND_OCT;
         dec_count = 1;
         dec_phase = (c == qsu_pkg::CH_QUOTE) ? qsu_pkg::PH_BODY : qsu_pkg::PH_ERR;
      end else if (dec_phase inside {qsu_pkg::PH_BODY, qsu_pkg::PH_ESC, qsu_pkg::PH_XU,
                                     qsu_pkg::PH_DIGITS}) begin
         if (dec_count < qsu_pkg::MAX_CHARS) dec_count++;
         case (dec_phase)
            qsu_pkg::PH_BODY: body_char(c);
            qsu_pkg::PH_ESC: begin
               dec_phase = qsu_pkg::PH_BODY;
               if (c == qsu_pkg::CH_NUL) begin
                  dec_phase = qsu_pkg::PH_ERR;
               end else if (c == qsu_pkg::CH_BSL || c == qsu_pkg::CH_QUOTE ||
                            c == qsu_pkg::CH_APOS) begin
                  emit_byte(c);
               end else if (c == qsu_pkg::CH_N) begin
                  emit_byte(qsu_pkg::CH_LF);
               end else if (c == qsu_pkg::CH_R) begin
                  emit_byte(qsu_pkg::CH_CR);
               end else if (c == qsu_pkg::CH_T) begin
                  emit_byte(qsu_pkg::CH_TAB);
               end else if (c >= qsu_pkg::CH_ZERO && c <= qsu_pkg::CH_SEVEN) begin
                  dec_code  = 32'(c - qsu_pkg::CH_ZERO);
                  dec_ndig  = 4'd1;
                  dec_kind  = qsu_pkg::KIND_OCT;
                  dec_phase = qsu_pkg::PH_DIGITS;
               end else if (c == qsu_pkg::CH_X || c == qsu_pkg::CH_U) begin
                  dec_kind  = (c == qsu_pkg::CH_U) ? qsu_pkg::KIND_U : qsu_pkg::KIND_X;
                  dec_phase = qsu_pkg::PH_XU;
               end else begin
                  emit_byte(qsu_pkg::CH_BSL);
                  emit_byte(c);
               end
            end
            qsu_pkg::PH_XU: begin
               hv = hex_digit(c);
               if (hv >= 0) begin
                  dec_code  = 32'(hv);
                  dec_ndig  = 4'd1;
                  dec_phase = qsu_pkg::PH_DIGITS;
               end else begin
                  emit_byte(qsu_pkg::CH_BSL);
                  emit_byte((dec_kind == qsu_pkg::KIND_U) ? qsu_pkg::CH_U : qsu_pkg::CH_X);
                  body_char(c);
               end
            end
            default: begin
               if (dec_kind == qsu_pkg::KIND_OCT) begin
                  hv  = (c >= qsu_pkg::CH_ZERO && c <= qsu_pkg::CH_SEVEN) ?
                        int'(c - qsu_pkg::CH_ZERO) : -1;
                  lim = qsu_pkg::LIMIT_OCT;
               end else begin
                  hv  = hex_digit(c);
                  lim = (dec_kind == qsu_pkg::KIND_U) ? qsu_pkg::LIMIT_U : qsu_pkg::LIMIT_X;
               end
               if (hv >= 0) begin
                  if (dec_kind == qsu_pkg::KIND_OCT) dec_code = dec_code * 32'd8 + 32'(hv);
                  else dec_code = dec_code * 32'd16 + 32'(hv);
                  dec_ndig = dec_ndig + 4'd1;
                  if (dec_ndig >= lim) begin
                     emit_code_point(dec_code);
                     dec_phase = qsu_pkg::PH_BODY;
                  end
               end else begin
                  emit_code_point(dec_code);
                  body_char(c);
               end
            end
         endcase
      end
      st  = (dec_phase == qsu_pkg::PH_DONE) ? qsu_pkg::ST_CLOSED :
            (dec_phase == qsu_pkg::PH_ERR) ? qsu_pkg::ST_ERROR : qsu_pkg::ST_PARSING;
      cnt = (st == qsu_pkg::ST_CLOSED) ? 16'(dec_count) : 16'd0;
   endtask

   task automatic send_char(input logic [7:0] c, input logic s, input logic known = 1'b0,
                            input logic [1:0] known_st = qsu_pkg::ST_PARSING,
                            input logic [15:0] known_cnt = 16'd0);
      logic [1:0]  st;
      logic [15:0] cnt;
      while ($urandom_range(99) < src_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_ch        <= c;
      req_start_req <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (s || (dec_phase inside {qsu_pkg::PH_BODY, qsu_pkg::PH_ESC, qsu_pkg::PH_XU,
                                  qsu_pkg::PH_DIGITS})) sent_items++;
      decode_char(c, s, st, cnt);
      if (known) begin
         expected_beats.push_back('{8'h00, 1'b0, known_st, known_cnt, 1'b1});
      end else if (dec_bytes.size() == 0) begin
         expected_beats.push_back('{8'h00, 1'b0, st, cnt, 1'b1});
      end else begin
         foreach (dec_bytes[k])
            expected_beats.push_back('{dec_bytes[k], 1'b1, st, cnt, k == dec_bytes.size() - 1});
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == qsu_pkg::CH_QUOTE || c == qsu_pkg::CH_BSL || c == qsu_pkg::CH_CR ||
             c == qsu_pkg::CH_LF);
      return c;
   endfunction

   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(21);
      if (v < 10) return 8'(qsu_pkg::CH_ZERO + v);
      if (v < 16) return 8'(qsu_pkg::CH_LA + v - 10);
      return 8'(qsu_pkg::CH_UA + v - 16);
   endfunction

   task automatic send_escape();
      logic [7:0] simple_esc [6];
      int         n;
      simple_esc = '{qsu_pkg::CH_BSL, qsu_pkg::CH_QUOTE, qsu_pkg::CH_APOS, qsu_pkg::CH_N,
                     qsu_pkg::CH_R, qsu_pkg::CH_T};
      send_char(qsu_pkg::CH_BSL, 1'b0);
      case ($urandom_range(6))
         0: send_char(simple_esc[$urandom_range(5)], 1'b0);
         1: begin
            n = ($urandom_range(2) == 0) ? 3 : $urandom_range(1, 3);
            repeat (n) send_char(8'(qsu_pkg::CH_ZERO + $urandom_range(7)), 1'b0);
         end
         2: begin
            send_char(qsu_pkg::CH_U, 1'b0);
            n = ($urandom_range(2) == 0) ? 4 : $urandom_range(1, 4);
            repeat (n) send_char(rand_hex_char(), 1'b0);
         end
         3: begin
            send_char(qsu_pkg::CH_X, 1'b0);
            n = ($urandom_range(2) == 0) ? 8 : $urandom_range(1, 8);
            repeat (n) send_char(rand_hex_char(), 1'b0);
         end
         4: send_char($urandom_range(1) ? qsu_pkg::CH_U : qsu_pkg::CH_X, 1'b0);
         default: send_char(8'($urandom_range(1, 255)), 1'b0);
      endcase
   endtask

   task automatic send_random_string();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_char(8'($urandom_range(255)), 1'b1);
         repeat ($urandom_range(3)) send_char(8'($urandom_range(255)), 1'b0);
         return;
      end
      send_char(qsu_pkg::CH_QUOTE, 1'b1);
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(1)) send_char(plain_char(), 1'b0);
         else send_escape();
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
         send_char(qsu_pkg::CH_QUOTE, 1'b0);
      end else if (pick < 88) begin
         case ($urandom_range(2))
            0: send_char(qsu_pkg::CH_NUL, 1'b0);
            1: send_char(qsu_pkg::CH_CR, 1'b0);
            default: send_char(qsu_pkg::CH_LF, 1'b0);
         endcase
      end else if (pick < 94) begin
         send_char(qsu_pkg::CH_BSL, 1'b0);
         send_char(qsu_pkg::CH_NUL, 1'b0);
      end
      if ($urandom_range(3) == 0) send_char(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: rsp %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            $display("%0t: rsp beat expected none actual %0h", $time,
                     {rsp_out_byte, rsp_byte_valid, rsp_status, rsp_chars_read, rsp_last});
         end else begin
            want = expected_beats.pop_front();
            check_field("out_byte", 16'(want.out_byte), 16'(rsp_out_byte));
            check_field("byte_valid", 16'(want.byte_valid), 16'(rsp_byte_valid));
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("chars_read", want.chars_read, rsp_chars_read);
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      dir_tab = '{
         '{8'h41,             1'b0, 1'b1, qsu_pkg::ST_PARSING, 16'd0},
         '{8'h71,             1'b1, 1'b1, qsu_pkg::ST_ERROR,   16'd0},
         '{8'h79,             1'b0, 1'b1, qsu_pkg::ST_ERROR,   16'd0},
         '{qsu_pkg::CH_QUOTE, 1'b1, 1'b1, qsu_pkg::ST_PARSING, 16'd0},
         '{8'hFF,             1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_BSL,   1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_APOS,  1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_BSL,   1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_U,     1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{8'h67,             1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_BSL,   1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{8'h31,             1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_QUOTE, 1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{8'h7A,             1'b0, 1'b1, qsu_pkg::ST_CLOSED,  16'd10},
         '{qsu_pkg::CH_QUOTE, 1'b1, 1'b1, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_BSL,   1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_X,     1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_UF,    1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_QUOTE, 1'b1, 1'b1, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_BSL,   1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_CR,    1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_BSL,   1'b0, 1'b0, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_NUL,   1'b0, 1'b1, qsu_pkg::ST_ERROR,   16'd0},
         '{qsu_pkg::CH_QUOTE, 1'b1, 1'b1, qsu_pkg::ST_PARSING, 16'd0},
         '{qsu_pkg::CH_LF,    1'b0, 1'b1, qsu_pkg::ST_ERROR,   16'd0},
         '{qsu_pkg::CH_NUL,   1'b1, 1'b1, qsu_pkg::ST_ERROR,   16'd0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tab[i])
         send_char(dir_tab[i].ch, dir_tab[i].start, dir_tab[i].known, dir_tab[i].status,
                   dir_tab[i].chars_read);
      hold_until_drained();
      for (int ph = 0; ph < 3; ph++) begin
         src_idle   = (ph == 0) ? 35 : (ph == 1) ? 52 : 0;
         rsp_idle   = (ph == 0) ? 52 : (ph == 1) ? 35 : 0;
         sent_items = 0;
         while (sent_items < PHASE_ITEMS) send_random_string();
         hold_until_drained();
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
